[rtl/core/cpc_pkg.sv]
package cpc_pkg;

  // Input operations.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_FULL  = 2'd3
  } op_e;

  // Phase codes as they appear on the result.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_CHARGE  = 3'd2;
  localparam logic [2:0] PH_DISCHG  = 3'd3;
  localparam logic [2:0] PH_HOLD    = 3'd4;
  localparam logic [2:0] PH_ERR_SEQ = 3'd5;
  localparam logic [2:0] PH_ERR_CHG = 3'd6;
  localparam logic [2:0] PH_ERR_BAT = 3'd7;

  localparam logic [1:0] LED_OFF = 2'd0;
  localparam logic [1:0] LED_CHG = 2'd1;
  localparam logic [1:0] LED_ERR = 2'd2;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_PRE  = 2'd1,
    STEP_DIS  = 2'd2,
    STEP_TOP  = 2'd3
  } step_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPTOR_BAD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_BATTERY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_TMO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOPOFF      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE   = 3'd6;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [12:0] RST_ADAPTOR_BAD = 13'd4400;
  localparam logic [12:0] RST_FULL        = 13'd3900;
  localparam logic [12:0] RST_BAD_BATTERY = 13'd2500;
  localparam logic [9:0]  RST_MAIN_TMO    = 10'd300;
  localparam logic [7:0]  RST_TOPOFF      = 8'd20;
  localparam logic [7:0]  RST_PRECHARGE   = 8'd60;
  localparam logic [7:0]  RST_DISCHARGE   = 8'd30;

  localparam logic [7:0] SECS_PER_MIN  = 8'd60;
  localparam logic [5:0] LAST_SEC      = 6'd59;

  typedef struct packed {
    logic [12:0] adaptor_bad_mv;
    logic [12:0] full_mv;
    logic [12:0] bad_battery_mv;
    logic [9:0]  main_timeout_minutes;
    logic [7:0]  topoff_minutes;
    logic [7:0]  precharge_seconds;
    logic [7:0]  discharge_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [12:0] battery_mv;
    logic        ac_present;
  } req_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       charger_enable;
    logic [1:0] led_mode;
    logic       full_detect_armed;
    logic       charger_pulsed;
    logic       start_rejected;
  } rsp_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       chg_en;
    logic [1:0] led;
    logic       armed;
    logic [5:0] min_secs;
    logic [9:0] main_mins;
    logic [7:0] step_secs;
    step_e      step;
    logic [7:0] topoff_left;
  } st_t;

  function automatic logic [9:0] min1_10(logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic [7:0] min1_8(logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  // Abort the sequence: everything stops, phase and LED take the given values.
  function automatic st_t quit(st_t s, logic [2:0] ph, logic [1:0] led);
    st_t r;
    r             = s;
    r.chg_en      = 1'b0;
    r.armed       = 1'b0;
    r.min_secs    = '0;
    r.main_mins   = '0;
    r.step_secs   = '0;
    r.step        = STEP_NONE;
    r.topoff_left = '0;
    r.phase       = ph;
    r.led         = led;
    return r;
  endfunction

endpackage

[rtl/core/cpc_cfg_regs.sv]
module cpc_cfg_regs
  import cpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adaptor_bad_mv       <= RST_ADAPTOR_BAD;
      cfg_q.full_mv              <= RST_FULL;
      cfg_q.bad_battery_mv       <= RST_BAD_BATTERY;
      cfg_q.main_timeout_minutes <= RST_MAIN_TMO;
      cfg_q.topoff_minutes       <= RST_TOPOFF;
      cfg_q.precharge_seconds    <= RST_PRECHARGE;
      cfg_q.discharge_seconds    <= RST_DISCHARGE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ADAPTOR_BAD: cfg_q.adaptor_bad_mv       <= cfg_data_i[12:0];
        REG_FULL:        cfg_q.full_mv              <= cfg_data_i[12:0];
        REG_BAD_BATTERY: cfg_q.bad_battery_mv       <= cfg_data_i[12:0];
        REG_MAIN_TMO:    cfg_q.main_timeout_minutes <= cfg_data_i[9:0];
        REG_TOPOFF:      cfg_q.topoff_minutes       <= cfg_data_i[7:0];
        REG_PRECHARGE:   cfg_q.precharge_seconds    <= cfg_data_i[7:0];
        REG_DISCHARGE:   cfg_q.discharge_seconds    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/cpc_core.sv]
module cpc_core
  import cpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output rsp_t rsp_o
);

  st_t   st_q, st_d;
  step_e which;
  logic  pulsed, rejected;

  always_comb begin
    st_d     = st_q;
    which    = STEP_NONE;
    pulsed   = 1'b0;
    rejected = 1'b0;
    unique case (op_e'(req_i.operation))
      OP_TICK: begin
        if (st_d.step != STEP_NONE) begin
          if (st_d.step_secs != 8'd0) begin
            st_d.step_secs = st_d.step_secs - 8'd1;
          end
          if (st_d.step_secs == 8'd0) begin
            which     = st_d.step;
            st_d.step = STEP_NONE;
            unique case (which)
              STEP_PRE: begin
                if (st_d.phase != PH_CHARGE) begin
                  st_d = quit(st_d, PH_ERR_SEQ, LED_OFF);
                end else if (req_i.battery_mv < cfg_i.bad_battery_mv) begin
                  st_d = quit(st_d, PH_ERR_BAT, LED_ERR);
                end else begin
                  st_d.armed = 1'b1;
                end
              end
              STEP_DIS: begin
                if (st_d.phase != PH_DISCHG) begin
                  st_d = quit(st_d, PH_ERR_SEQ, LED_OFF);
                end else if (req_i.battery_mv < cfg_i.bad_battery_mv) begin
                  st_d = quit(st_d, PH_ERR_BAT, LED_ERR);
                end else begin
                  st_d.chg_en = 1'b1;
                  if (req_i.battery_mv < cfg_i.full_mv) begin
                    st_d.phase = PH_CHARGE;
                    st_d.armed = 1'b1;
                  end else begin
                    st_d.topoff_left = min1_8(cfg_i.topoff_minutes);
                    st_d.step        = STEP_TOP;
                    st_d.step_secs   = SECS_PER_MIN;
                  end
                end
              end
              STEP_TOP: begin
                if (st_d.phase != PH_DISCHG) begin
                  st_d = quit(st_d, PH_ERR_SEQ, LED_ERR);
                end else if (st_d.topoff_left > 8'd1) begin
                  st_d.topoff_left = st_d.topoff_left - 8'd1;
                  st_d.step        = STEP_TOP;
                  st_d.step_secs   = SECS_PER_MIN;
                end else begin
                  st_d.topoff_left = '0;
                  st_d.chg_en      = 1'b1;
                  st_d.armed       = 1'b0;
                  st_d.led         = LED_OFF;
                  st_d.phase       = PH_HOLD;
                end
              end
              default: ;
            endcase
          end
        end
        // The main timer runs on the state left by the step timer.
        if (st_d.main_mins != 10'd0) begin
          if (st_d.min_secs == LAST_SEC) begin
            st_d.min_secs = '0;
            if (st_d.main_mins > 10'd1) begin
              st_d.main_mins = st_d.main_mins - 10'd1;
            end else begin
              st_d.chg_en = 1'b1;
              if (st_d.phase == PH_DISCHG) begin
                st_d.phase = PH_CHARGE;
              end
              st_d.main_mins = min1_10(cfg_i.main_timeout_minutes);
              pulsed         = 1'b1;
            end
          end else begin
            st_d.min_secs = st_d.min_secs + 6'd1;
          end
        end
      end
      OP_START: begin
        if (st_d.phase < PH_START || st_d.phase > PH_HOLD) begin
          st_d.phase = PH_IDLE;
          if (!req_i.ac_present) begin
            rejected = 1'b1;
          end else begin
            st_d.chg_en = 1'b1;
            if (req_i.battery_mv > cfg_i.adaptor_bad_mv) begin
              st_d = quit(st_d, PH_ERR_CHG, LED_ERR);
            end else begin
              st_d.phase     = PH_CHARGE;
              st_d.main_mins = min1_10(cfg_i.main_timeout_minutes);
              st_d.min_secs  = '0;
              st_d.led       = LED_CHG;
              st_d.armed     = 1'b0;
              st_d.step      = STEP_PRE;
              st_d.step_secs = min1_8(cfg_i.precharge_seconds);
            end
          end
        end
      end
      OP_STOP: begin
        if (st_d.phase >= PH_START && st_d.phase <= PH_HOLD) begin
          st_d = quit(st_d, PH_IDLE, LED_OFF);
        end
        st_d.led    = LED_OFF;
        st_d.chg_en = 1'b0;
      end
      OP_FULL: begin
        if (st_d.armed) begin
          st_d.armed = 1'b0;
          if (st_d.phase != PH_CHARGE) begin
            st_d = quit(st_d, PH_ERR_SEQ, LED_OFF);
          end else begin
            st_d.phase     = PH_DISCHG;
            st_d.chg_en    = 1'b0;
            st_d.step      = STEP_DIS;
            st_d.step_secs = min1_8(cfg_i.discharge_seconds);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, chg_en: 1'b0, led: LED_OFF, armed: 1'b0,
                min_secs: '0, main_mins: '0, step_secs: '0, step: STEP_NONE,
                topoff_left: '0};
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  always_comb begin
    rsp_o.phase             = st_d.phase;
    rsp_o.charger_enable    = st_d.chg_en;
    rsp_o.led_mode          = st_d.led;
    rsp_o.full_detect_armed = st_d.armed;
    rsp_o.charger_pulsed    = pulsed;
    rsp_o.start_rejected    = rejected;
  end

  // A pending step only exists while charging or discharging.
  a_step_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.step != STEP_NONE |-> (st_q.phase == PH_CHARGE || st_q.phase == PH_DISCHG))
    else $error("step pending outside charge phases");

  // Full detection is armed only in the charge phase.
  a_armed_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.armed |-> st_q.phase == PH_CHARGE)
    else $error("full detection armed outside charge phase");

  // The main timer runs only inside a charge sequence.
  a_main_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.main_mins != 10'd0 |-> (st_q.phase >= PH_START && st_q.phase <= PH_HOLD))
    else $error("main timer running outside charge sequence");

  // The second counter wraps at the end of each minute.
  a_min_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.min_secs <= LAST_SEC)
    else $error("second counter out of range");

endmodule

[rtl/core/battery_charge_phase_controller_top.sv]
// An accepted request lands in the input register; its result is loaded into
// the result register. Throughput: one request per cycle unless out_stall_i
// holds a full result register; the state update is one combinational pass
// between the input register and the result register.
// Reset: asynchronous, active low; sequencer idle, configuration at defaults.
module battery_charge_phase_controller_top
  import cpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  req_t                  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rsp_t                  out_rsp_o
);

  cfg_t cfg;
  req_t req_q;
  logic req_valid_q;
  rsp_t rsp_d, rsp_q;
  logic rsp_valid_q;
  logic out_free, advance;

  // The result register can load when empty or being drained this cycle.
  assign out_free   = !rsp_valid_q || !out_stall_i;
  assign advance    = req_valid_q && out_free;
  assign in_stall_o = req_valid_q && !out_free;

  cpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cpc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        req_valid_q <= in_valid_i;
      end
      if (out_free) begin
        rsp_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
